/* hw/rtl/phs_pkg.sv */
// ----------------------------------------------------------------------------
// phs_pkg: shared types and codes of the periodic task scheduler
// Operation codes carried on the input tuser and the control word that the
// top level broadcasts to every cell of the sorted chain.
// ----------------------------------------------------------------------------
`default_nettype none

package phs_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TAKE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // ins: insert the broadcast entry; popins: drop the head and insert it
  typedef struct packed {
    logic ins;
    logic popins;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/phs_cell.sv */
// ----------------------------------------------------------------------------
// phs_cell: one slot of the sorted task chain
// Holds one task and compares it with the broadcast entry. Takes the entry,
// its left neighbor or its right neighbor so that the chain stays sorted by
// due time, then by arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module phs_cell
  import phs_pkg::*;
#(
  parameter int TIME_BITS = 40,
  parameter int AW        = 6
) (
  input  wire logic                 clk_i,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic                 first_i,
  input  wire logic                 occ_i,
  input  wire logic [TIME_BITS-1:0] x_due_i,
  input  wire logic [15:0]          x_period_i,
  input  wire logic [AW-1:0]        x_arr_i,
  input  wire logic [15:0]          x_tag_i,
  input  wire logic [TIME_BITS-1:0] left_due_i,
  input  wire logic [15:0]          left_period_i,
  input  wire logic [AW-1:0]        left_arr_i,
  input  wire logic [15:0]          left_tag_i,
  input  wire logic                 left_before_i,
  input  wire logic [TIME_BITS-1:0] right_due_i,
  input  wire logic [15:0]          right_period_i,
  input  wire logic [AW-1:0]        right_arr_i,
  input  wire logic [15:0]          right_tag_i,
  input  wire logic                 right_before_i,
  output logic [TIME_BITS-1:0]      due_o,
  output logic [15:0]               period_o,
  output logic [AW-1:0]             arr_o,
  output logic [15:0]               tag_o,
  output logic                      before_o
);

  logic [TIME_BITS-1:0] due_q, due_d;
  logic [15:0]          period_q, period_d;
  logic [AW-1:0]        arr_q, arr_d;
  logic [15:0]          tag_q, tag_d;

  // an empty slot sorts after everything
  assign before_o = occ_i && ((due_q < x_due_i) || ((due_q == x_due_i) && (arr_q < x_arr_i)));

  always_comb begin
    due_d    = due_q;
    period_d = period_q;
    arr_d    = arr_q;
    tag_d    = tag_q;
    if (ctrl_i.ins && !before_o) begin
      if (first_i || left_before_i) begin
        due_d    = x_due_i;
        period_d = x_period_i;
        arr_d    = x_arr_i;
        tag_d    = x_tag_i;
      end else begin
        due_d    = left_due_i;
        period_d = left_period_i;
        arr_d    = left_arr_i;
        tag_d    = left_tag_i;
      end
    end else if (ctrl_i.popins) begin
      if (right_before_i) begin
        due_d    = right_due_i;
        period_d = right_period_i;
        arr_d    = right_arr_i;
        tag_d    = right_tag_i;
      end else if (first_i || before_o) begin
        due_d    = x_due_i;
        period_d = x_period_i;
        arr_d    = x_arr_i;
        tag_d    = x_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    due_q    <= due_d;
    period_q <= period_d;
    arr_q    <= arr_d;
    tag_q    <= tag_d;
  end

  assign due_o    = due_q;
  assign period_o = period_q;
  assign arr_o    = arr_q;
  assign tag_o    = tag_q;

endmodule

`default_nettype wire

/* hw/rtl/periodic_task_heap_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_task_heap_scheduler: bounded set of periodic tasks, earliest first
// Keeps up to MAX_TASKS tasks sorted in a chain of cells, head at cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_axis: tuser carries the operation (add, take, clear),
//   tdata the period and the tag of a task to add. Output beats on m_axis
//   come only from a take: tdata holds due time and tag, tuser the empty and
//   overflow flags.
//   A take on a nonempty set accepts the beat, reads out the head and
//   reschedules it, then drops the head in the reinsert state and
//   reinserts it through the cell chain; the chain compares in parallel,
//   independent of MAX_TASKS. A take on an empty set needs no reinsert.
//   The result is valid on m_axis in the cycle after the take is accepted.
//   A take is held off while a result still waits and the receiver is not
//   ready; add and clear beats go on while the result waits.
//   Reset empties the set; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_heap_scheduler
  import phs_pkg::*;
#(
  parameter int MAX_TASKS = 64,
  parameter int TIME_BITS = 40,
  localparam int OutW = ((TIME_BITS + 16 + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [31:0]     s_axis_tdata,  // period[15:0], task_tag[31:16]
  input  wire logic [1:0]      s_axis_tuser,  // op[1:0]
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [OutW-1:0]      m_axis_tdata,  // due_time[TIME_BITS-1:0], out_tag above it
  output logic [1:0]           m_axis_tuser   // empty_res[0], overflow[1]
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_REINS = 1'b1;

  logic state_q, state_d;
  logic [CW-1:0] count_q, count_d;

  logic [TIME_BITS-1:0] x_due_q;
  logic [15:0]          x_period_q;
  logic [AW-1:0]        x_arr_q;
  logic [15:0]          x_tag_q;

  logic                 m_valid_q;
  logic [TIME_BITS-1:0] o_due_q;
  logic [15:0]          o_tag_q;
  logic                 o_empty_q;
  logic                 o_ovf_q;

  logic in_go, add_go, take_go, clear_go, pop_go;
  logic [15:0] in_period, in_tag;
  cell_ctrl_t ctrl;

  logic [TIME_BITS-1:0] x_due;
  logic [15:0]          x_period;
  logic [AW-1:0]        x_arr;
  logic [15:0]          x_tag;

  logic [TIME_BITS-1:0] due_w    [MAX_TASKS];
  logic [15:0]          period_w [MAX_TASKS];
  logic [AW-1:0]        arr_w    [MAX_TASKS];
  logic [15:0]          tag_w    [MAX_TASKS];
  logic                 before_w [MAX_TASKS];

  logic [TIME_BITS:0]   sum;
  logic                 sum_ovf;

  assign in_period = s_axis_tdata[15:0];
  assign in_tag    = s_axis_tdata[31:16];

  assign s_axis_tready = (state_q == ST_IDLE) &&
                         ((s_axis_tuser != OP_TAKE) || !m_valid_q || m_axis_tready);
  assign in_go    = s_axis_tvalid && s_axis_tready;
  assign add_go   = in_go && (s_axis_tuser == OP_ADD) && (count_q < CW'(MAX_TASKS));
  assign take_go  = in_go && (s_axis_tuser == OP_TAKE);
  assign clear_go = in_go && (s_axis_tuser == OP_CLEAR);
  assign pop_go   = take_go && (count_q != '0);

  assign ctrl.ins    = add_go;
  assign ctrl.popins = (state_q == ST_REINS);

  // arrival order equals the fill count: both advance on add and restart on clear
  always_comb begin
    if (state_q == ST_REINS) begin
      x_due    = x_due_q;
      x_period = x_period_q;
      x_arr    = x_arr_q;
      x_tag    = x_tag_q;
    end else begin
      x_due    = TIME_BITS'(in_period);
      x_period = in_period;
      x_arr    = count_q[AW-1:0];
      x_tag    = in_tag;
    end
  end

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic [TIME_BITS-1:0] l_due, r_due;
    logic [15:0]          l_period, r_period, l_tag, r_tag;
    logic [AW-1:0]        l_arr, r_arr;
    logic                 l_before, r_before;

    if (i == 0) begin : g_first
      assign l_due = x_due; assign l_period = x_period;
      assign l_arr = x_arr; assign l_tag = x_tag; assign l_before = 1'b1;
    end else begin : g_mid_l
      assign l_due = due_w[i-1]; assign l_period = period_w[i-1];
      assign l_arr = arr_w[i-1]; assign l_tag = tag_w[i-1];
      assign l_before = before_w[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_last
      assign r_due = x_due; assign r_period = x_period;
      assign r_arr = x_arr; assign r_tag = x_tag; assign r_before = 1'b0;
    end else begin : g_mid_r
      assign r_due = due_w[i+1]; assign r_period = period_w[i+1];
      assign r_arr = arr_w[i+1]; assign r_tag = tag_w[i+1];
      assign r_before = before_w[i+1];
    end

    phs_cell #(
      .TIME_BITS(TIME_BITS),
      .AW       (AW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .first_i       (i == 0),
      .occ_i         (CW'(i) < count_q),
      .x_due_i       (x_due),
      .x_period_i    (x_period),
      .x_arr_i       (x_arr),
      .x_tag_i       (x_tag),
      .left_due_i    (l_due),
      .left_period_i (l_period),
      .left_arr_i    (l_arr),
      .left_tag_i    (l_tag),
      .left_before_i (l_before),
      .right_due_i   (r_due),
      .right_period_i(r_period),
      .right_arr_i   (r_arr),
      .right_tag_i   (r_tag),
      .right_before_i(r_before),
      .due_o         (due_w[i]),
      .period_o      (period_w[i]),
      .arr_o         (arr_w[i]),
      .tag_o         (tag_w[i]),
      .before_o      (before_w[i])
    );
  end

  // reschedule the head; carry out of the top bit means saturation
  assign sum     = {1'b0, due_w[0]} + (TIME_BITS + 1)'(period_w[0]);
  assign sum_ovf = sum[TIME_BITS];

  always_comb begin
    state_d = ST_IDLE;
    if (pop_go) begin
      state_d = ST_REINS;
    end
  end

  always_comb begin
    count_d = count_q;
    if (clear_go) begin
      count_d = '0;
    end else if (add_go) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (take_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_go) begin
      x_due_q    <= sum_ovf ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
      x_period_q <= period_w[0];
      x_arr_q    <= arr_w[0];
      x_tag_q    <= tag_w[0];
    end
    if (take_go) begin
      o_due_q   <= pop_go ? due_w[0] : '0;
      o_tag_q   <= pop_go ? tag_w[0] : '0;
      o_empty_q <= !pop_go;
      o_ovf_q   <= pop_go && sum_ovf;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutW'({o_tag_q, o_due_q});
  assign m_axis_tuser  = {o_ovf_q, o_empty_q};

`ifndef SYNTHESIS
  a_reins_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REINS) |-> $past(pop_go))
    else $error("reinsert cycle without a take of a nonempty set");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TASKS))
    else $error("task count above capacity");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REINS) |-> !s_axis_tready)
    else $error("input accepted during reinsert");

  a_count_stable_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REINS) |-> $stable(count_q))
    else $error("task count changed across a take");
`endif

endmodule

`default_nettype wire
